[src/act_pkg.sv]
// shared types and constants for the ansi csi text terminal
// used by act_ctrl, act_dp and ansi_csi_text_terminal_unit; no dependencies
package act_pkg;

  localparam int DEFAULT_ROWS     = 25;
  localparam int DEFAULT_COLUMNS  = 80;
  localparam int DEFAULT_TAB_STOP = 4;
  localparam logic [7:0] ATTR_RESET = 8'h70;

  typedef struct packed {
    logic        action;
    logic [7:0]  byte_in;
    logic [10:0] cell_address;
  } req_word_t;

  typedef struct packed {
    logic [4:0]  row_now;
    logic [6:0]  column_now;
    logic [7:0]  attribute_now;
    logic [15:0] cell_data;
    logic        unsupported;
  } rsp_word_t;

  // follow-up work that an executed item asks for
  typedef enum logic [1:0] {
    OP_DONE,
    OP_FILL,
    OP_SCROLL,
    OP_TAB
  } op_t;

  typedef struct packed {
    logic idle;
    logic load;
    logic exec;
    logic fill;
    logic scr_rd;
    logic scr_wr;
    logic tab_mod;
    logic tab_step;
    logic rsp;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic fill_last;
    logic scr_last;
    logic tab_big;
    logic tab_zero;
    logic tab_stop;
    logic tab_scroll;
    logic rsp_free;
  } sts_t;

endpackage

[src/act_ctrl.sv]
// sequencer of the terminal: clearing pass, execute, fill, scroll, tab, respond
// depends on act_pkg
module act_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  act_pkg::sts_t sts,
  output act_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_SCR_RD,
    S_SCR_WR,
    S_TAB_MOD,
    S_TAB_STEP,
    S_RESP
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: begin
          if (sts.fill_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          case (sts.op)
            act_pkg::OP_FILL:   state <= S_FILL;
            act_pkg::OP_SCROLL: state <= S_SCR_RD;
            act_pkg::OP_TAB:    state <= S_TAB_MOD;
            default:            state <= S_RESP;
          endcase
        end
        S_FILL: begin
          if (sts.fill_last) state <= S_RESP;
        end
        S_SCR_RD: begin
          state <= S_SCR_WR;
        end
        S_SCR_WR: begin
          state <= sts.scr_last ? S_RESP : S_SCR_RD;
        end
        S_TAB_MOD: begin
          if (!sts.tab_big) state <= sts.tab_zero ? S_RESP : S_TAB_STEP;
        end
        S_TAB_STEP: begin
          if (sts.tab_scroll) state <= S_SCR_RD;
          else if (sts.tab_stop) state <= S_RESP;
        end
        S_RESP: begin
          if (sts.rsp_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.idle     = (state == S_IDLE);
    cmd.load     = (state == S_IDLE) && req_valid;
    cmd.exec     = (state == S_EXEC);
    cmd.fill     = (state == S_FILL) || (state == S_CLEAR);
    cmd.scr_rd   = (state == S_SCR_RD);
    cmd.scr_wr   = (state == S_SCR_WR);
    cmd.tab_mod  = (state == S_TAB_MOD);
    cmd.tab_step = (state == S_TAB_STEP);
    cmd.rsp      = (state == S_RESP);
  end

endmodule

[src/act_dp.sv]
// datapath of the terminal: cell memory, cursor, attribute, csi parser, result register
// depends on act_pkg; driven by act_ctrl commands
module act_dp #(
  parameter int ROWS     = act_pkg::DEFAULT_ROWS,
  parameter int COLUMNS  = act_pkg::DEFAULT_COLUMNS,
  parameter int TAB_STOP = act_pkg::DEFAULT_TAB_STOP
) (
  input  logic               clk,
  input  logic               rst,
  input  act_pkg::cmd_t      cmd,
  output act_pkg::sts_t      sts,
  input  act_pkg::req_word_t req_word,
  input  logic [7:0]         dflt_attr,
  input  logic               rsp_stall,
  output logic               rsp_valid,
  output act_pkg::rsp_word_t rsp_word
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int IW    = $clog2(CELLS);
  localparam int XW    = IW + 1;
  localparam int RW    = $clog2(ROWS + 1);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int NW    = $clog2(ROWS + 1);
  localparam int MW    = $clog2(COLUMNS + TAB_STOP + 1);

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CSI   = "[";
  localparam logic [7:0] CH_SEP   = ";";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_FINAL = 8'h40;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] FIN_A    = "A";
  localparam logic [7:0] FIN_B    = "B";
  localparam logic [7:0] FIN_C    = "C";
  localparam logic [7:0] FIN_D    = "D";
  localparam logic [7:0] FIN_E    = "E";
  localparam logic [7:0] FIN_F    = "F";
  localparam logic [7:0] FIN_H    = "H";
  localparam logic [7:0] FIN_J    = "J";
  localparam logic [7:0] FIN_K    = "K";
  localparam logic [7:0] FIN_S    = "S";
  localparam logic [7:0] FIN_T    = "T";
  localparam logic [7:0] FIN_M    = "m";
  localparam logic [11:0] PARAM_MAX = 12'd4095;

  typedef enum logic [2:0] {
    PH_TEXT,
    PH_ESC,
    PH_P1,
    PH_P2,
    PH_MORE
  } phase_t;

  logic [15:0] mem [CELLS];
  logic [15:0] rd_data;

  act_pkg::req_word_t item;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [7:0]    attr;
  phase_t        phase;
  logic [11:0]   p1;
  logic [11:0]   p2;
  logic [XW-1:0] idx;
  logic [XW-1:0] last_idx;
  logic [XW-1:0] shift;
  logic          up;
  logic [15:0]   fill_val;
  logic [MW-1:0] rem;
  logic          unsup;

  // decode of the held item against the current state
  logic [RW-1:0] d_row;
  logic [CW-1:0] d_col;
  logic [7:0]    d_attr;
  phase_t        d_phase;
  logic [11:0]   d_p1;
  logic [11:0]   d_p2;
  act_pkg::op_t  d_op;
  logic          d_unsup;
  logic          d_put;
  logic [XW-1:0] d_from;
  logic [XW-1:0] d_to;
  logic          d_up;
  logic [NW-1:0] d_n;

  logic [7:0]    ch;
  logic [XW-1:0] line_idx;
  logic [XW-1:0] cur_idx;
  logic          last_cell;
  logic [11:0]   cnt;
  logic signed [14:0] srow;
  logic signed [14:0] scol;
  logic signed [14:0] scnt;
  logic [8:0]    sgr_res;
  logic          rd_hit;
  logic [XW-1:0] src_up;
  logic [XW-1:0] src;
  logic          src_ok;
  logic          we;
  logic [IW-1:0] waddr;
  logic [15:0]   wdata;
  logic [IW-1:0] raddr;
  logic          rsp_free;

  function automatic logic [RW-1:0] clamp_row(input logic signed [14:0] v);
    logic [RW-1:0] r;
    if (v < 15'sd1) r = RW'(1);
    else if (v > $signed(15'(ROWS))) r = RW'(ROWS);
    else r = v[RW-1:0];
    return r;
  endfunction

  function automatic logic [CW-1:0] clamp_col(input logic signed [14:0] v);
    logic [CW-1:0] r;
    if (v < 15'sd1) r = CW'(1);
    else if (v > $signed(15'(COLUMNS))) r = CW'(COLUMNS);
    else r = v[CW-1:0];
    return r;
  endfunction

  function automatic logic [11:0] dig_acc(input logic [11:0] p, input logic [7:0] c);
    logic [15:0] v;
    v = {4'b0, p} * 16'd10 + {12'b0, c[3:0]};
    return (v > {4'b0, PARAM_MAX}) ? PARAM_MAX : v[11:0];
  endfunction

  function automatic logic [2:0] vga(input logic [11:0] c);
    return {c[0], c[1], c[2]};
  endfunction

  // returns {ok, new attribute}
  function automatic logic [8:0] sgr(input logic [11:0] p, input logic [7:0] a,
                                     input logic [7:0] dflt);
    logic [8:0] r;
    r = {1'b1, a};
    if (p == 12'd0) r = {1'b1, dflt};
    else if (p == 12'd1) r = {1'b1, a | 8'h88};
    else if (p == 12'd2) r = {1'b1, a & 8'h77};
    else if (p >= 12'd30 && p <= 12'd37) r = {1'b1, a[7:3], vga(p - 12'd30)};
    else if (p >= 12'd40 && p <= 12'd47) r = {1'b1, a[7], vga(p - 12'd40), a[3:0]};
    else if (p >= 12'd90 && p <= 12'd97) r = {1'b1, a[7:4], 1'b1, vga(p - 12'd90)};
    else if (p >= 12'd100 && p <= 12'd107) r = {1'b1, 1'b1, vga(p - 12'd100), a[3:0]};
    else r = {1'b0, a};
    return r;
  endfunction

  assign ch        = item.byte_in;
  assign line_idx  = (XW'(row) - XW'(1)) * XW'(COLUMNS);
  assign cur_idx   = line_idx + XW'(col) - XW'(1);
  assign last_cell = (row == RW'(ROWS)) && (col == CW'(COLUMNS));
  assign cnt       = (p1 == 12'd0) ? 12'd1 : p1;
  assign srow      = 15'(row);
  assign scol      = 15'(col);
  assign scnt      = 15'(cnt);
  assign sgr_res   = sgr(p1, attr, dflt_attr);
  assign rd_hit    = 32'(item.cell_address) < 32'(CELLS);

  always_comb begin
    d_row   = row;
    d_col   = col;
    d_attr  = attr;
    d_phase = phase;
    d_p1    = p1;
    d_p2    = p2;
    d_op    = act_pkg::OP_DONE;
    d_unsup = 1'b0;
    d_put   = 1'b0;
    d_from  = '0;
    d_to    = '0;
    d_up    = 1'b1;
    d_n     = NW'(1);
    if (!item.action) begin
      case (phase)
        PH_TEXT: begin
          if (ch == CH_BS) begin
            if (col == CW'(1)) begin
              d_col = CW'(COLUMNS);
              if (row > RW'(1)) begin
                d_row = row - RW'(1);
              end else begin
                d_op = act_pkg::OP_SCROLL;
                d_up = 1'b0;
              end
            end else begin
              d_col = col - CW'(1);
            end
          end else if (ch == CH_TAB) begin
            if (!last_cell) d_op = act_pkg::OP_TAB;
          end else if (ch == CH_LF) begin
            d_col = CW'(1);
            if (row < RW'(ROWS)) d_row = row + RW'(1);
            else d_op = act_pkg::OP_SCROLL;
          end else if (ch == CH_ESC) begin
            d_phase = PH_ESC;
          end else begin
            d_put = 1'b1;
            if (col == CW'(COLUMNS)) begin
              d_col = CW'(1);
              if (row < RW'(ROWS)) d_row = row + RW'(1);
              else d_op = act_pkg::OP_SCROLL;
            end else begin
              d_col = col + CW'(1);
            end
          end
        end
        PH_ESC: begin
          if (ch == CH_CSI) begin
            d_phase = PH_P1;
            d_p1    = '0;
            d_p2    = '0;
          end else begin
            d_phase = PH_TEXT;
          end
        end
        default: begin
          if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (phase == PH_P1) d_p1 = dig_acc(p1, ch);
            if (phase == PH_P2) d_p2 = dig_acc(p2, ch);
          end else if (ch == CH_SEP) begin
            if (phase == PH_P1) d_phase = PH_P2;
            else d_phase = PH_MORE;
          end else if (ch < CH_SPACE || ch > CH_TILDE) begin
            d_phase = PH_TEXT;
          end else if (ch >= CH_FINAL) begin
            d_phase = PH_TEXT;
            case (ch)
              FIN_A: d_row = clamp_row(srow - scnt);
              FIN_B: d_row = clamp_row(srow + scnt);
              FIN_C: d_col = clamp_col(scol + scnt);
              FIN_D: d_col = clamp_col(scol - scnt);
              FIN_E: begin
                d_row = clamp_row(srow + scnt);
                d_col = CW'(1);
              end
              FIN_F: begin
                d_row = clamp_row(srow - scnt);
                d_col = CW'(1);
              end
              FIN_H: begin
                d_row = clamp_row(scnt);
                d_col = clamp_col((p2 == 12'd0) ? 15'sd1 : 15'(p2));
              end
              FIN_J: begin
                d_op = act_pkg::OP_FILL;
                if (p1 == 12'd0) begin
                  d_from = cur_idx;
                  d_to   = XW'(CELLS - 1);
                end else if (p1 == 12'd1) begin
                  d_to = cur_idx;
                end else if (p1 == 12'd2) begin
                  d_to = XW'(CELLS - 1);
                end else begin
                  d_op = act_pkg::OP_DONE;
                end
              end
              FIN_K: begin
                d_op = act_pkg::OP_FILL;
                if (p1 == 12'd0) begin
                  d_from = cur_idx;
                  d_to   = line_idx + XW'(COLUMNS - 1);
                end else if (p1 == 12'd1) begin
                  d_from = line_idx;
                  d_to   = cur_idx;
                end else if (p1 == 12'd2) begin
                  d_from = line_idx;
                  d_to   = line_idx + XW'(COLUMNS - 1);
                end else begin
                  d_op = act_pkg::OP_DONE;
                end
              end
              FIN_S, FIN_T: begin
                d_op = act_pkg::OP_SCROLL;
                d_up = (ch == FIN_S);
                d_n  = (cnt > 12'(ROWS)) ? NW'(ROWS) : NW'(cnt);
              end
              FIN_M: begin
                if (sgr_res[8]) d_attr = sgr_res[7:0];
                else d_unsup = 1'b1;
              end
              default: d_unsup = 1'b1;
            endcase
          end
        end
      endcase
    end
  end

  // scroll source: up copies from below, down from above; out of range reads as zero
  assign src_up = idx + shift;
  assign src    = up ? src_up : idx - shift;
  assign src_ok = up ? (src_up < XW'(CELLS)) : (idx >= shift);
  assign raddr  = cmd.scr_rd ? src[IW-1:0] : IW'(item.cell_address);

  always_comb begin
    we    = 1'b0;
    waddr = idx[IW-1:0];
    wdata = fill_val;
    if (cmd.exec && d_put) begin
      we    = 1'b1;
      waddr = cur_idx[IW-1:0];
      wdata = {attr, ch};
    end else if (cmd.fill) begin
      we = 1'b1;
    end else if (cmd.scr_wr) begin
      we    = 1'b1;
      wdata = src_ok ? rd_data : 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  assign rsp_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= RW'(1);
      col       <= CW'(1);
      attr      <= act_pkg::ATTR_RESET;
      phase     <= PH_TEXT;
      p1        <= '0;
      p2        <= '0;
      idx       <= '0;
      last_idx  <= XW'(CELLS - 1);
      fill_val  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        row   <= d_row;
        col   <= d_col;
        attr  <= d_attr;
        phase <= d_phase;
        p1    <= d_p1;
        p2    <= d_p2;
        unsup <= d_unsup;
        if (d_op == act_pkg::OP_FILL) begin
          idx      <= d_from;
          last_idx <= d_to;
          fill_val <= {dflt_attr, CH_SPACE};
        end
        if (d_op == act_pkg::OP_SCROLL) begin
          up    <= d_up;
          idx   <= d_up ? '0 : XW'(CELLS - 1);
          shift <= XW'(d_n) * XW'(COLUMNS);
        end
        if (d_op == act_pkg::OP_TAB) rem <= MW'(col) - MW'(1);
      end
      if (cmd.fill) idx <= idx + XW'(1);
      if (cmd.scr_wr) idx <= up ? idx + XW'(1) : idx - XW'(1);
      if (cmd.tab_mod && rem >= MW'(TAB_STOP)) rem <= rem - MW'(TAB_STOP);
      if (cmd.tab_step) begin
        if (col == CW'(COLUMNS)) begin
          col <= CW'(1);
          if (row < RW'(ROWS)) begin
            row <= row + RW'(1);
          end else begin
            up    <= 1'b1;
            idx   <= '0;
            shift <= XW'(COLUMNS);
          end
        end else begin
          col <= col + CW'(1);
          rem <= rem + MW'(1);
        end
      end
      if (cmd.rsp && rsp_free) begin
        rsp_valid              <= 1'b1;
        rsp_word.row_now       <= 5'(row);
        rsp_word.column_now    <= 7'(col);
        rsp_word.attribute_now <= attr;
        rsp_word.cell_data     <= (item.action && rd_hit) ? rd_data : 16'h0000;
        rsp_word.unsupported   <= unsup && !item.action;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= req_word;
  end

  always_comb begin
    sts            = '0;
    sts.op         = d_op;
    sts.fill_last  = (idx == last_idx);
    sts.scr_last   = up ? (idx == XW'(CELLS - 1)) : (idx == '0);
    sts.tab_big    = (rem >= MW'(TAB_STOP));
    sts.tab_zero   = (rem == '0);
    sts.tab_stop   = (col == CW'(COLUMNS)) || (rem + MW'(1) == MW'(TAB_STOP));
    sts.tab_scroll = (col == CW'(COLUMNS)) && (row == RW'(ROWS));
    sts.rsp_free   = rsp_free;
  end

endmodule

[src/ansi_csi_text_terminal_unit.sv]
// Text terminal fed one byte (or one cell read) per word, giving one result word per item.
// After reset a clearing pass zeroes the cell memory, one cell per cycle, with req_stall high.
// An item is then accepted, executed and responded to, plus its memory work: a J or K clear
// writes the cleared cells in turn, a scroll (S, T, wrap at the bottom, backspace at the
// top-left) moves every screen cell through the read and then the write port of the single
// cell memory, and a tab reduces the column offset by TAB_STOP while it is not below it,
// then steps one column at a time.
// Requests are taken again as soon as the result is in the output register.
// Depends on act_pkg, act_ctrl and act_dp.
module ansi_csi_text_terminal_unit #(
  parameter int ROWS     = act_pkg::DEFAULT_ROWS,
  parameter int COLUMNS  = act_pkg::DEFAULT_COLUMNS,
  parameter int TAB_STOP = act_pkg::DEFAULT_TAB_STOP
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  act_pkg::req_word_t req_word,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output act_pkg::rsp_word_t rsp_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  act_pkg::cmd_t cmd;
  act_pkg::sts_t sts;
  logic [7:0]    dflt_attr;

  assign pready    = 1'b1;
  assign prdata    = (paddr == 2'b00) ? {24'b0, dflt_attr} : 32'b0;
  assign req_stall = !cmd.idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      dflt_attr <= act_pkg::ATTR_RESET;
    end else if (psel && penable && pwrite && pready && paddr == 2'b00) begin
      dflt_attr <= pwdata[7:0];
    end
  end

  act_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  act_dp #(
    .ROWS     (ROWS),
    .COLUMNS  (COLUMNS),
    .TAB_STOP (TAB_STOP)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_word  (req_word),
    .dflt_attr (dflt_attr),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp_word  (rsp_word)
  );

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("accepted a word while the previous item was still running");

  a_exec_follows_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> $past(req_valid && !req_stall))
    else $error("execute without an accepted word");

  a_rsp_loaded: assert property (@(posedge clk) disable iff (rst)
    cmd.rsp && sts.rsp_free |=> rsp_valid)
    else $error("result not presented after respond");

  a_unsup_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.unsupported |-> rsp_word.cell_data == 16'h0000)
    else $error("unsupported flag on a cell read");

endmodule
